// ===== rtl/core/plcc_pkg.sv =====
// Shared types and constants for the prime list center cut block.
package plcc_pkg;

    localparam int LIMIT_W     = 9;    // width of limits, candidates and results
    localparam int ENTRY_W     = 8;    // width of one stored list entry
    localparam int MAX_LIMIT   = 256;
    localparam int TABLE_SLOTS = 64;
    localparam int ADDR_W      = $clog2(TABLE_SLOTS);
    localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int RESULT_CAP  = 55;
    localparam int BITCNT_W    = $clog2(LIMIT_W);

    typedef struct packed {
        logic [LIMIT_W-1:0] upper_limit;
        logic [LIMIT_W-1:0] cut_half;
    } t_in;

    typedef struct packed {
        logic [LIMIT_W-1:0] prime_value;
        logic               last_entry;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ONE,
        S_TWO,
        S_CAND,
        S_FETCH,
        S_LOAD,
        S_DIV,
        S_TEST,
        S_ADD,
        S_WIN,
        S_E_RD,
        S_E_WR
    } t_state;

endpackage

// ===== rtl/core/prime_list_center_cut_top.sv =====
// Prime list builder with centered window output, bit-serial trial division.
//
// Each request carries an upper limit (saturated to 256) and a cut half C.
// The block rebuilds the list 1, 2, 3, 5, 7, ... of every value up to the
// limit, counting 1 as prime, into a 64-entry table memory. Candidates are
// tested by trial division against the stored primes from 2 upward, with a
// shared restoring divider that produces one quotient bit per cycle; a
// candidate is composite at the first zero remainder and prime once the
// quotient falls below the divisor (divisor squared above the candidate) or
// the stored primes run out. The list is then cut: an even-length list of at
// least 2C entries yields its centered 2C entries, an odd-length list of at
// least 2C-1 entries yields its centered 2C-1 entries, any other list goes out
// whole, and a cut half of zero or an empty list yields nothing. The final
// result of a request carries last_entry. Each trial divisor passes through
// a table read, a load, 9 divide steps and a test, and each emitted entry
// through a table read and an output write, so the one-bit-per-cycle
// divider sets the run time of a request. One request is worked at a
// time; a new request is taken once the last result has moved into the
// output register, even while that result still waits to be taken.
module prime_list_center_cut_top
    import plcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    // Table memory: one write port, one registered read port
    logic [ENTRY_W-1:0] mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Control and datapath registers
    t_state              r_state, n_state;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic [LIMIT_W-1:0]  r_cut, n_cut;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [LIMIT_W-1:0]  r_cand, n_cand;
    logic [COUNT_W-1:0]  r_j, n_j;
    logic [ENTRY_W-1:0]  r_div, n_div;
    logic [LIMIT_W-1:0]  r_dvd, n_dvd;     // dividend in, quotient out
    logic [ENTRY_W-1:0]  r_rem, n_rem;
    logic [BITCNT_W-1:0] r_bit, n_bit;
    logic [COUNT_W-1:0]  r_start, n_start;
    logic [COUNT_W-1:0]  r_len, n_len;
    logic [COUNT_W-1:0]  r_k, n_k;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    // Divider step and window arithmetic
    logic [LIMIT_W-1:0]  div_trial;
    logic [LIMIT_W-1:0]  div_diff;
    logic                div_ge;
    logic [LIMIT_W:0]    cut2;
    logic [LIMIT_W:0]    cnt_ext;
    logic [LIMIT_W:0]    half_ext;
    logic [LIMIT_W:0]    win_start;
    logic [LIMIT_W:0]    win_len;
    logic [COUNT_W-1:0]  emit_idx;
    logic                emit_last;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Restoring division: shift one dividend bit into the remainder per cycle
    assign div_trial = {r_rem, r_dvd[LIMIT_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_div};
    assign div_diff  = div_trial - {1'b0, r_div};

    assign cut2     = {r_cut, 1'b0};
    assign cnt_ext  = (LIMIT_W + 1)'(r_count);
    assign half_ext = (LIMIT_W + 1)'(r_count >> 1);

    assign emit_idx  = r_start + r_k;
    assign emit_last = (r_k + 1'b1) == r_len;

    // Hold the emit address while an entry waits on a stalled output
    always_comb begin
        rd_addr = (r_state == S_E_RD || r_state == S_E_WR)
                  ? emit_idx[ADDR_W-1:0] : r_j[ADDR_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_cut       = r_cut;
        n_count     = r_count;
        n_cand      = r_cand;
        n_j         = r_j;
        n_div       = r_div;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_start     = r_start;
        n_len       = r_len;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_ready;
        o_ready     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_count[ADDR_W-1:0];
        wr_data     = r_cand[ENTRY_W-1:0];
        win_start   = '0;
        win_len     = cnt_ext;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    // Saturate the limit and start a fresh list
                    n_limit = (i_data.upper_limit > LIMIT_W'(MAX_LIMIT))
                              ? LIMIT_W'(MAX_LIMIT) : i_data.upper_limit;
                    n_cut   = i_data.cut_half;
                    n_count = '0;
                    n_state = S_ONE;
                end
            end
            S_ONE: begin
                if (r_limit >= LIMIT_W'(1)) begin
                    wr_en   = 1'b1;
                    wr_data = ENTRY_W'(1);
                    n_count = r_count + 1'b1;
                    n_state = S_TWO;
                end else begin
                    n_state = S_WIN;
                end
            end
            S_TWO: begin
                if (r_limit >= LIMIT_W'(2)) begin
                    wr_en   = 1'b1;
                    wr_data = ENTRY_W'(2);
                    n_count = r_count + 1'b1;
                    n_cand  = LIMIT_W'(3);
                    n_state = S_CAND;
                end else begin
                    n_state = S_WIN;
                end
            end
            S_CAND: begin
                // Stop at the limit or once the table is full
                if (r_cand > r_limit || r_count == COUNT_W'(TABLE_SLOTS)) begin
                    n_state = S_WIN;
                end else begin
                    n_j     = COUNT_W'(1);
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                // Divisors exhausted: the candidate is prime
                n_state = (r_j >= r_count) ? S_ADD : S_LOAD;
            end
            S_LOAD: begin
                n_div   = r_rd_data;
                n_dvd   = r_cand;
                n_rem   = '0;
                n_bit   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff[ENTRY_W-1:0] : div_trial[ENTRY_W-1:0];
                n_dvd = {r_dvd[LIMIT_W-2:0], div_ge};
                n_bit = r_bit + 1'b1;
                if (r_bit == BITCNT_W'(LIMIT_W - 1)) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (r_div == '0 || r_rem == '0) begin
                    // Composite: drop the candidate
                    n_cand  = r_cand + 1'b1;
                    n_state = S_CAND;
                end else if (r_dvd < LIMIT_W'(r_div)) begin
                    // Quotient below divisor means divisor squared exceeds it
                    n_state = S_ADD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_ADD: begin
                wr_en   = 1'b1;
                n_count = r_count + 1'b1;
                n_cand  = r_cand + 1'b1;
                n_state = S_CAND;
            end
            S_WIN: begin
                if (r_cut == '0 || r_count == '0) begin
                    n_state = S_IDLE;
                end else begin
                    if (!r_count[0] && cnt_ext >= cut2) begin
                        win_start = half_ext - (LIMIT_W + 1)'(r_cut);
                        win_len   = cut2;
                    end else if (r_count[0] && cnt_ext >= cut2 - 1'b1) begin
                        win_start = half_ext - (LIMIT_W + 1)'(r_cut) + 1'b1;
                        win_len   = cut2 - 1'b1;
                    end
                    if (win_len > (LIMIT_W + 1)'(RESULT_CAP)) begin
                        win_len = (LIMIT_W + 1)'(RESULT_CAP);
                    end
                    n_start = win_start[COUNT_W-1:0];
                    n_len   = win_len[COUNT_W-1:0];
                    n_k     = '0;
                    n_state = S_E_RD;
                end
            end
            S_E_RD: begin
                n_state = S_E_WR;
            end
            S_E_WR: begin
                // Advance only when the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out.prime_value = LIMIT_W'(r_rd_data);
                    n_out.last_entry  = emit_last;
                    n_out_valid       = 1'b1;
                    n_k               = r_k + 1'b1;
                    n_state           = emit_last ? S_IDLE : S_E_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        r_cut   <= n_cut;
        r_cand  <= n_cand;
        r_j     <= n_j;
        r_div   <= n_div;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_start <= n_start;
        r_len   <= n_len;
        r_k     <= n_k;
        r_out   <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== test/tb_prime_list_center_cut_top.sv =====
// Self-checking testbench for the prime list center cut block.
module tb_prime_list_center_cut_top;
    import plcc_pkg::*;

    // Idle cycles allowed with no handshake on either side. One full-range
    // request runs the bit-serial divider over every candidate before its
    // first entry, so this is several times the slowest correct gap.
    localparam int WATCHDOG_LIMIT = 100000;
    // Cycles to keep watching once every expected entry has arrived.
    // This covers a request with no entries that is still being worked.
    localparam int DRAIN_CYCLES   = 20000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    t_out expected_entries[$];
    int   fail_count = 0;
    int   idle_cycles = 0;

    prime_list_center_cut_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Build the list for one request and queue the entries of its window.
    function automatic void predict_center_cut(t_in req);
        int prime_list[TABLE_SLOTS];
        int list_len;
        int limit;
        int half;
        int first;
        int span;
        bit is_prime;
        limit = int'(req.upper_limit);
        half  = int'(req.cut_half);
        // Saturate the limit to the largest supported value.
        if (limit > MAX_LIMIT) begin
            limit = MAX_LIMIT;
        end
        list_len = 0;
        if (limit >= 1 && list_len < TABLE_SLOTS) begin
            prime_list[list_len] = 1;
            list_len++;
        end
        if (limit >= 2 && list_len < TABLE_SLOTS) begin
            prime_list[list_len] = 2;
            list_len++;
        end
        for (int cand = 3; cand <= limit && list_len < TABLE_SLOTS; cand++) begin
            // Trial divide by stored primes from 2 upward; stop at the first
            // divisor or once the divisor squared exceeds the candidate.
            is_prime = 1'b1;
            for (int j = 1; j < list_len; j++) begin
                if (prime_list[j] == 0 || cand % prime_list[j] == 0) begin
                    is_prime = 1'b0;
                    break;
                end
                if (cand < prime_list[j] * prime_list[j]) begin
                    break;
                end
            end
            if (is_prime) begin
                prime_list[list_len] = cand;
                list_len++;
            end
        end
        // Empty list or empty window: no entries at all.
        if (half == 0 || list_len == 0) begin
            return;
        end
        if (list_len % 2 == 0 && list_len >= 2 * half) begin
            first = list_len / 2 - half;
            span  = 2 * half;
        end else if (list_len % 2 == 1 && list_len >= 2 * half - 1) begin
            first = list_len / 2 - (half - 1);
            span  = 2 * half - 1;
        end else begin
            first = 0;
            span  = list_len;
        end
        if (span > RESULT_CAP) begin
            span = RESULT_CAP;
        end
        for (int k = 0; k < span; k++) begin
            t_out entry;
            entry.prime_value = (first + k < list_len) ?
                                LIMIT_W'(prime_list[first + k]) : '0;
            entry.last_entry  = (k + 1 == span);
            expected_entries.push_back(entry);
        end
    endfunction

    // Present one request and hold it until the block takes it. Leave valid
    // high on return; the caller lowers it only when a gap follows.
    task automatic send_request(input int limit, input int half);
        t_in req;
        req.upper_limit = LIMIT_W'(limit);
        req.cut_half    = LIMIT_W'(half);
        i_valid <= 1'b1;
        i_data  <= req;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predict_center_cut(req);
    endtask

    // Drop valid for a number of cycles; zero keeps back-to-back requests.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Random gap between requests: back to back half the time, else longer.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            return 0;
        end
        return $urandom_range(1, (pick == 9) ? 12 : 3);
    endfunction

    // Zero limit, limit of one, saturation above the supported range.
    task automatic test_limit_edges();
        send_request(0, 1);
        send_request(1, 1);
        send_request(2, 1);
        pause_sender(random_gap());
        send_request(3, 1);
        send_request(256, 1);
        send_request(257, 3);
        pause_sender(random_gap());
        send_request(511, 2);
        send_request(300, 0);
        send_request(1, 511);
    endtask

    // Zero cut, all-ones cut, cut wider than any list.
    task automatic test_cut_edges();
        send_request(0, 0);
        send_request(1, 0);
        send_request(100, 256);
        pause_sender(random_gap());
        send_request(256, 511);
        send_request(256, 0);
        send_request(3, 2);
    endtask

    // Window exactly the list length, narrower or wider, odd and even lists.
    task automatic test_window_boundaries();
        send_request(10, 2);    // odd list of 5, centered 3
        send_request(11, 3);    // even list of 6, whole window
        pause_sender(random_gap());
        send_request(13, 4);    // odd list of 7, whole window
        send_request(13, 5);    // window too wide, whole list
        send_request(256, 27);  // odd list of 55, centered 53
        send_request(256, 28);  // window equals the full list
        send_request(12, 1);    // even list of 6, centered 2
    endtask

    // Random requests in bursts; most use small limits to keep runs short.
    task automatic test_random_traffic(input int count);
        int sent;
        int burst;
        int pick;
        int limit;
        int half;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < count; b++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    limit = $urandom_range(1, 40);
                end else if (pick < 88) begin
                    limit = $urandom_range(41, 256);
                end else if (pick < 94) begin
                    limit = $urandom_range(257, 511);
                end else begin
                    limit = 0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    half = $urandom_range(1, 8);
                end else if (pick < 85) begin
                    half = $urandom_range(9, 30);
                end else if (pick < 93) begin
                    half = $urandom_range(31, 511);
                end else begin
                    half = 0;
                end
                send_request(limit, half);
                sent++;
            end
            pause_sender($urandom_range(1, 10));
        end
    endtask

    // Receiver: pick a new stall pattern each time the mode counter runs out.
    int   stall_mode  = 0;
    int   mode_cycles = 0;
    logic toggle_bit  = 1'b0;
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(0, 3);
            mode_cycles = 64;
        end
        mode_cycles--;
        toggle_bit = ~toggle_bit;
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= toggle_bit;
        endcase
    end

    // Compare each accepted entry with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_entries.size() == 0) begin
                $error("unexpected entry: prime_value %0d, last_entry %0d",
                       o_data.prime_value, o_data.last_entry);
                fail_count++;
            end else begin
                t_out want;
                want = expected_entries.pop_front();
                if (o_data.prime_value !== want.prime_value) begin
                    $error("prime_value: expected %0d, actual %0d",
                           want.prime_value, o_data.prime_value);
                    fail_count++;
                end
                if (o_data.last_entry !== want.last_entry) begin
                    $error("last_entry: expected %0d, actual %0d",
                           want.last_entry, o_data.last_entry);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_prime_list_center_cut_top NOT OK");
            $finish;
        end
    end

    initial begin
        // Hold reset at the start, then release it once.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_limit_edges();
        test_cut_edges();
        test_window_boundaries();
        test_random_traffic(100);
        pause_sender(1);

        // Drain: wait for every expected entry, then watch for strays.
        while (expected_entries.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_entries.size() == 0) begin
            $display("tb_prime_list_center_cut_top OK");
        end else begin
            $display("tb_prime_list_center_cut_top NOT OK");
        end
        $finish;
    end

endmodule
